// ----- rtl/ajdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ajdc_pkg
// Shared types and fixed constants for the adaptive joystick direction
// classifier: threshold width, reset values, step limit and clamp bounds.
// ----------------------------------------------------------------------------
package ajdc_pkg;

   localparam int THRESH_BITS = 12;
   localparam int STEP_BITS   = 6;

   typedef logic [THRESH_BITS-1:0] thresh_type;

   // Bounds for one family of thresholds: a moved value below min_val becomes
   // under_val, and one above max_val becomes over_val.
   typedef struct packed {
      thresh_type min_val;
      thresh_type max_val;
      thresh_type under_val;
      thresh_type over_val;
   } clamp_type;

   localparam thresh_type LOW_RESET   = 12'd1500;
   localparam thresh_type HIGH_RESET  = 12'd3000;
   localparam thresh_type WIN_RESET   = 12'd400;

   localparam logic [STEP_BITS-1:0] STEP_LIMIT = 6'd50;

   localparam clamp_type LOW_CLAMP  = '{min_val:   12'd1000, max_val:  12'd2000,
                                        under_val: 12'd1100, over_val: 12'd1900};
   localparam clamp_type HIGH_CLAMP = '{min_val:   12'd2500, max_val:  12'd3500,
                                        under_val: 12'd2600, over_val: 12'd3400};

endpackage

// ----- rtl/ajdc_adapt.sv -----
// ----------------------------------------------------------------------------
// ajdc_adapt
// Next value of one threshold: when the sample lies within the window of the
// threshold, move by -d/16 (toward zero, at most 50), then clamp.
// ----------------------------------------------------------------------------
module ajdc_adapt
   import ajdc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic [SAMPLE_BITS-1:0] sample,
   input  thresh_type             thresh,
   input  thresh_type             window_half,
   input  clamp_type              limits,
   output thresh_type             thresh_next
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;

   logic signed [DIFF_BITS-1:0]   diff;
   logic [SAMPLE_BITS-1:0]        mag;
   logic [SAMPLE_BITS-1:0]        win_ext;
   logic [SAMPLE_BITS-1:0]        step_raw;
   logic [STEP_BITS-1:0]          step;
   logic                          in_window;
   logic signed [THRESH_BITS:0]   th_ext;
   logic signed [THRESH_BITS:0]   moved;
   thresh_type                    clamped;

   // distance from threshold and its magnitude
   assign diff    = signed'({1'b0, sample}) - signed'(DIFF_BITS'(thresh));
   assign mag     = diff[DIFF_BITS-1] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
   assign win_ext = SAMPLE_BITS'(window_half);
   assign in_window = (mag <= win_ext);

   // step size: magnitude / 16, saturated at the limit
   assign step_raw = mag >> 4;
   assign step     = (step_raw > SAMPLE_BITS'(STEP_LIMIT)) ? STEP_LIMIT
                                                           : step_raw[STEP_BITS-1:0];

   // move away from the sample, then clamp into the allowed band
   assign th_ext = signed'({1'b0, thresh});
   always_comb begin
      if (diff[DIFF_BITS-1]) begin
         moved = th_ext + signed'((THRESH_BITS+1)'(step));
      end else begin
         moved = th_ext - signed'((THRESH_BITS+1)'(step));
      end
      if (moved < signed'({1'b0, limits.min_val})) begin
         clamped = limits.under_val;
      end else if (moved > signed'({1'b0, limits.max_val})) begin
         clamped = limits.over_val;
      end else begin
         clamped = moved[THRESH_BITS-1:0];
      end
   end

   // a threshold outside the window keeps its value unclamped
   assign thresh_next = in_window ? clamped : thresh;

endmodule

// ----- rtl/adaptive_joystick_direction_classifier.sv -----
// ----------------------------------------------------------------------------
// adaptive_joystick_direction_classifier
// Classifies joystick (x, y) samples into stop/right/left/backward/forward
// against four self-adjusting thresholds.
// ----------------------------------------------------------------------------
// One result per sample transaction, at a sustained rate of one per clock
// while rsp_ready stays high. The accepting edge loads the input register;
// the threshold update and flag compare between it and the response register
// land there when the transaction advances, which waits while a held
// response is not taken. The threshold registers are written in the same
// cycle the response register loads, so each sample sees the thresholds left
// by the one before it. window_half is written through the csr port, which
// is always ready and must only be written while idle.
// ----------------------------------------------------------------------------
module adaptive_joystick_direction_classifier
   import ajdc_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_x_sample,
   input  logic [SAMPLE_BITS-1:0] req_y_sample,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_stop_flag,
   output logic                   rsp_right_flag,
   output logic                   rsp_left_flag,
   output logic                   rsp_backward_flag,
   output logic                   rsp_forward_flag,
   output thresh_type             rsp_x_low_now,
   output thresh_type             rsp_x_high_now,
   output thresh_type             rsp_y_low_now,
   output thresh_type             rsp_y_high_now,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  thresh_type             csr_window_half
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_x_ff, s1_y_ff;
   logic                   out_valid_ff, out_valid_in;
   thresh_type             window_ff;
   thresh_type             x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   thresh_type             x_low_in, x_high_in, y_low_in, y_high_in;
   logic                   stop_ff, right_ff, left_ff, backward_ff, forward_ff;
   logic                   advance;
   logic                   req_take;

   // flow control: stage 1 moves when the response register is free or draining
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_window_half;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_x_ff <= req_x_sample;
         s1_y_ff <= req_y_sample;
      end
   end

   // threshold update units
   ajdc_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_x_low (
      .sample(s1_x_ff), .thresh(x_low_ff), .window_half(window_ff),
      .limits(LOW_CLAMP), .thresh_next(x_low_in));
   ajdc_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_x_high (
      .sample(s1_x_ff), .thresh(x_high_ff), .window_half(window_ff),
      .limits(HIGH_CLAMP), .thresh_next(x_high_in));
   ajdc_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_y_low (
      .sample(s1_y_ff), .thresh(y_low_ff), .window_half(window_ff),
      .limits(LOW_CLAMP), .thresh_next(y_low_in));
   ajdc_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_y_high (
      .sample(s1_y_ff), .thresh(y_high_ff), .window_half(window_ff),
      .limits(HIGH_CLAMP), .thresh_next(y_high_in));

   // threshold state, written as the transaction moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= LOW_RESET;
         x_high_ff <= HIGH_RESET;
         y_low_ff  <= LOW_RESET;
         y_high_ff <= HIGH_RESET;
      end else if (advance) begin
         x_low_ff  <= x_low_in;
         x_high_ff <= x_high_in;
         y_low_ff  <= y_low_in;
         y_high_ff <= y_high_in;
      end
   end

   // direction flags against the updated thresholds
   logic x_below, x_above, y_below, y_above, x_inside, y_inside;
   assign x_below  = s1_x_ff < SAMPLE_BITS'(x_low_in);
   assign x_above  = s1_x_ff > SAMPLE_BITS'(x_high_in);
   assign y_below  = s1_y_ff < SAMPLE_BITS'(y_low_in);
   assign y_above  = s1_y_ff > SAMPLE_BITS'(y_high_in);
   assign x_inside = (s1_x_ff > SAMPLE_BITS'(x_low_in)) && !x_above;
   assign y_inside = (s1_y_ff > SAMPLE_BITS'(y_low_in)) && !y_above;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         stop_ff     <= x_inside && y_inside && (s1_x_ff != SAMPLE_BITS'(x_high_in))
                        && (s1_y_ff != SAMPLE_BITS'(y_high_in));
         right_ff    <= x_below;
         left_ff     <= x_above;
         backward_ff <= y_below;
         forward_ff  <= y_above;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_stop_flag     = stop_ff;
   assign rsp_right_flag    = right_ff;
   assign rsp_left_flag     = left_ff;
   assign rsp_backward_flag = backward_ff;
   assign rsp_forward_flag  = forward_ff;
   // thresholds only change when a new response loads, so they mirror it
   assign rsp_x_low_now     = x_low_ff;
   assign rsp_x_high_now    = x_high_ff;
   assign rsp_y_low_now     = y_low_ff;
   assign rsp_y_high_now    = y_high_ff;

   // checks
   a_low_band: assert property (@(posedge clock) disable iff (reset)
      x_low_ff >= LOW_CLAMP.min_val && x_low_ff <= LOW_CLAMP.max_val &&
      y_low_ff >= LOW_CLAMP.min_val && y_low_ff <= LOW_CLAMP.max_val)
      else $error("low threshold left its band");

   a_high_band: assert property (@(posedge clock) disable iff (reset)
      x_high_ff >= HIGH_CLAMP.min_val && x_high_ff <= HIGH_CLAMP.max_val &&
      y_high_ff >= HIGH_CLAMP.min_val && y_high_ff <= HIGH_CLAMP.max_val)
      else $error("high threshold left its band");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=>
         $stable(x_low_ff) && $stable(x_high_ff) && $stable(y_low_ff) && $stable(y_high_ff))
      else $error("thresholds changed while response stalled");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request accepted with both stages full");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(stop_ff && (right_ff || left_ff || backward_ff || forward_ff)))
      else $error("stop flag raised together with a direction flag");

endmodule

// ----- verif/adaptive_joystick_direction_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// adaptive_joystick_direction_classifier_tb
// Self-checking bench for the joystick direction classifier. Each accepted
// sample pair runs through a local model of the four adapting thresholds and
// the direction flags. The predicted result is queued and compared field by
// field with the response stream. Covers clamping, window edges, far-distance
// step saturation and sample extremes. Random phases run at several window
// settings, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_joystick_direction_classifier_tb
   import ajdc_pkg::*;
;

   localparam int SAMPLE_W      = 12;
   localparam int SAMPLE_MAX    = 4095;
   localparam int WINDOW_MAX    = 4095;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int IDLE_PERCENT  = 13;
   localparam int PHASE_ITEMS   = 85;
   localparam int PRINT_LIMIT   = 40;

   // Threshold tracking rules
   localparam int STEP_CAP     = 50;
   localparam int LOW_FLOOR    = 1000;
   localparam int LOW_CEIL     = 2000;
   localparam int LOW_REFLOOR  = 1100;
   localparam int LOW_RECEIL   = 1900;
   localparam int HIGH_FLOOR   = 2500;
   localparam int HIGH_CEIL    = 3500;
   localparam int HIGH_REFLOOR = 2600;
   localparam int HIGH_RECEIL  = 3400;

   typedef struct {
      logic       stop_flag;
      logic       right_flag;
      logic       left_flag;
      logic       backward_flag;
      logic       forward_flag;
      thresh_type x_low;
      thresh_type x_high;
      thresh_type y_low;
      thresh_type y_high;
   } heading_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_x_sample;
   logic [SAMPLE_W-1:0] req_y_sample;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_stop_flag;
   logic                rsp_right_flag;
   logic                rsp_left_flag;
   logic                rsp_backward_flag;
   logic                rsp_forward_flag;
   thresh_type          rsp_x_low_now;
   thresh_type          rsp_x_high_now;
   thresh_type          rsp_y_low_now;
   thresh_type          rsp_y_high_now;
   logic                csr_valid;
   logic                csr_ready;
   thresh_type          csr_window_half;

   // Model state: the threshold set and the adaptation window
   thresh_type model_x_low;
   thresh_type model_x_high;
   thresh_type model_y_low;
   thresh_type model_y_high;
   thresh_type model_window;

   heading_type pending_headings[$];

   bit idle_on;
   bit hold_request;
   int mismatch_count;
   int samples_sent;
   int results_checked;
   int window_writes;
   int cycle_count;

   adaptive_joystick_direction_classifier DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_x_sample      (req_x_sample),
      .req_y_sample      (req_y_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_stop_flag     (rsp_stop_flag),
      .rsp_right_flag    (rsp_right_flag),
      .rsp_left_flag     (rsp_left_flag),
      .rsp_backward_flag (rsp_backward_flag),
      .rsp_forward_flag  (rsp_forward_flag),
      .rsp_x_low_now     (rsp_x_low_now),
      .rsp_x_high_now    (rsp_x_high_now),
      .rsp_y_low_now     (rsp_y_low_now),
      .rsp_y_high_now    (rsp_y_high_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_half   (csr_window_half)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_headings.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Threshold model
   // ------------------------------------------------------------------------

   // Move one threshold away from a nearby sample by |d|/16 (capped), then
   // pull it back inside its band. Untouched thresholds are not clamped.
   function automatic thresh_type track_threshold(thresh_type th, int sample,
                                                  int floor_v, int ceil_v,
                                                  int refloor_v, int receil_v);
      int d;
      int mag;
      int step_size;
      int moved;
      d = sample - int'(th);
      if (d < -int'(model_window) || d > int'(model_window))
         return th;
      mag       = (d < 0) ? -d : d;
      step_size = mag / 16;
      if (step_size > STEP_CAP)
         step_size = STEP_CAP;
      moved = (d < 0) ? int'(th) + step_size : int'(th) - step_size;
      if (moved < floor_v)
         moved = refloor_v;
      if (moved > ceil_v)
         moved = receil_v;
      return thresh_type'(moved);
   endfunction

   // Update the threshold set for one sample pair and queue its heading
   function automatic void predict_heading(int x, int y);
      heading_type h;
      model_x_low  = track_threshold(model_x_low,  x, LOW_FLOOR, LOW_CEIL,
                                     LOW_REFLOOR, LOW_RECEIL);
      model_x_high = track_threshold(model_x_high, x, HIGH_FLOOR, HIGH_CEIL,
                                     HIGH_REFLOOR, HIGH_RECEIL);
      model_y_low  = track_threshold(model_y_low,  y, LOW_FLOOR, LOW_CEIL,
                                     LOW_REFLOOR, LOW_RECEIL);
      model_y_high = track_threshold(model_y_high, y, HIGH_FLOOR, HIGH_CEIL,
                                     HIGH_REFLOOR, HIGH_RECEIL);
      h.right_flag    = (x < int'(model_x_low));
      h.left_flag     = (x > int'(model_x_high));
      h.backward_flag = (y < int'(model_y_low));
      h.forward_flag  = (y > int'(model_y_high));
      h.stop_flag     = (x > int'(model_x_low)) && (x < int'(model_x_high)) &&
                        (y > int'(model_y_low)) && (y < int'(model_y_high));
      h.x_low  = model_x_low;
      h.x_high = model_x_high;
      h.y_low  = model_y_low;
      h.y_high = model_y_high;
      pending_headings.push_back(h);
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
      if (got !== want)
         log_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                results_checked, name, got, want));
   endtask

   always @(posedge clock) begin : result_monitor
      heading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_headings.size() == 0) begin
            log_mismatch($sformatf("result %0d arrived with nothing pending",
                                   results_checked));
         end else begin
            want = pending_headings.pop_front();
            check_field("stop_flag",     rsp_stop_flag,     want.stop_flag);
            check_field("right_flag",    rsp_right_flag,    want.right_flag);
            check_field("left_flag",     rsp_left_flag,     want.left_flag);
            check_field("backward_flag", rsp_backward_flag, want.backward_flag);
            check_field("forward_flag",  rsp_forward_flag,  want.forward_flag);
            check_field("x_low_now",     rsp_x_low_now,     want.x_low);
            check_field("x_high_now",    rsp_x_high_now,    want.x_high);
            check_field("y_low_now",     rsp_y_low_now,     want.y_low);
            check_field("y_high_now",    rsp_y_high_now,    want.y_high);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response side: random idling, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : response_side
      int hold_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one sample pair and hold it until the transaction completes
   task automatic send_sample(int x, int y);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= x[SAMPLE_W-1:0];
      req_y_sample <= y[SAMPLE_W-1:0];
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      samples_sent++;
      predict_heading(x, y);
   endtask

   // Stop offering, let every result drain and the pipeline settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_headings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(int w);
      wait_quiet();
      csr_valid       <= 1'b1;
      csr_window_half <= thresh_type'(w);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid    <= 1'b0;
      model_window = thresh_type'(w);
      window_writes++;
   endtask

   function automatic int clip_sample(int v);
      if (v < 0)
         return 0;
      if (v > SAMPLE_MAX)
         return SAMPLE_MAX;
      return v;
   endfunction

   // Half the samples lie close to a threshold of the axis, so the thresholds
   // actually move; the rest sits on the window edge, uniform or at the rails.
   function automatic int pick_axis_sample(thresh_type lo_th, thresh_type hi_th);
      int r;
      int th;
      int span;
      int off;
      r    = $urandom_range(0, 99);
      th   = $urandom_range(0, 1) ? int'(hi_th) : int'(lo_th);
      span = int'(model_window) + 24;
      if (span > 1000)
         span = 1000;
      if (r < 50) begin
         off = int'($urandom_range(0, 2 * span)) - span;
      end else if (r < 65) begin
         off = int'(model_window) + int'($urandom_range(0, 1));
         if ($urandom_range(0, 1))
            off = -off;
      end else if (r < 90) begin
         return int'($urandom_range(0, SAMPLE_MAX));
      end else begin
         return $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      end
      return clip_sample(th + off);
   endfunction

   task automatic send_random_samples(int count);
      int x;
      int y;
      for (int i = 0; i < count; i++) begin
         x = pick_axis_sample(model_x_low, model_x_high);
         y = pick_axis_sample(model_y_low, model_y_high);
         send_sample(x, y);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Widest window: x pinned low, y pinned high. Steps saturate at the cap,
   // x thresholds climb past their ceilings, y thresholds sink past floors.
   task automatic test_clamp_limits();
      write_window(WINDOW_MAX);
      repeat (11) send_sample(0, SAMPLE_MAX);
   endtask

   // Window 400: distance exactly on the edge, one past it, the largest distance
   // that does not move, the smallest that does, zero distance, a stop position.
   task automatic test_window_edges();
      int w;
      write_window(400);
      w = int'(model_window);
      send_sample(int'(model_x_low) + w, int'(model_y_high) - w);
      send_sample(int'(model_x_low) + w + 1, int'(model_y_high) - w - 1);
      send_sample(int'(model_x_low) + 15, int'(model_y_low) - 15);
      send_sample(int'(model_x_high) + 16, int'(model_y_high) - 16);
      send_sample(int'(model_x_high), int'(model_y_low));
      send_sample((int'(model_x_low) + int'(model_x_high)) / 2,
                  (int'(model_y_low) + int'(model_y_high)) / 2);
   endtask

   // Rails on both axes, then a zero window where only exact hits fall inside it
   task automatic test_sample_extremes();
      send_sample(0, 0);
      send_sample(SAMPLE_MAX, SAMPLE_MAX);
      send_sample(0, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, 0);
      write_window(0);
      send_sample(int'(model_x_low), int'(model_y_high));
      send_sample(int'(model_x_low) + 1, int'(model_y_high) - 1);
   endtask

   // Random phases over several window settings; one runs with no idling
   task automatic test_random_windows();
      int windows[7];
      windows = '{400, 800, WINDOW_MAX, 0, 799, 0, 0};
      windows[5] = $urandom_range(1, WINDOW_MAX);
      windows[6] = $urandom_range(1, 900);
      foreach (windows[i]) begin
         write_window(windows[i]);
         idle_on = (i != 1);
         send_random_samples(PHASE_ITEMS);
      end
      idle_on = 1'b1;
   endtask

   // Response side stalls for a long stretch while samples keep coming,
   // so the pipeline fills and back-pressures the request channel
   task automatic test_output_backpressure();
      write_window(600);
      hold_request = 1'b1;
      send_random_samples(24);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_x_sample    = '0;
      req_y_sample    = '0;
      csr_valid       = 1'b0;
      csr_window_half = '0;
      idle_on         = 1'b1;
      hold_request    = 1'b0;
      mismatch_count  = 0;
      samples_sent    = 0;
      results_checked = 0;
      window_writes   = 0;
      cycle_count     = 0;
      model_x_low     = thresh_type'(1500);
      model_x_high    = thresh_type'(3000);
      model_y_low     = thresh_type'(1500);
      model_y_high    = thresh_type'(3000);
      model_window    = thresh_type'(400);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clamp_limits();
      test_window_edges();
      test_sample_extremes();
      test_random_windows();
      test_output_backpressure();

      wait_quiet();

      $display("Run covered %0d samples and %0d checked results over %0d window writes,",
               samples_sent, results_checked, window_writes);
      $display("including windows 0 and 4095, all four clamps and a long output stall.");
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
